/* src/sfcp_pkg.sv */
// sfcp_pkg: shared types and constants of the framed command parser.
// No dependencies; imported by every module in src.
package sfcp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hE0;
	localparam logic [7:0] SYNC_SECOND = 8'h0E;

	localparam logic [7:0] TYPE_ENABLE  = 8'd1;
	localparam logic [7:0] TYPE_DISABLE = 8'd2;
	localparam logic [7:0] TYPE_VALUES  = 8'd3;

	localparam logic [3:0] POS_HUNT      = 4'd0;
	localparam logic [3:0] POS_SYNC      = 4'd1;
	localparam logic [3:0] POS_TYPE      = 4'd2;
	localparam logic [3:0] PAYLOAD_START = 4'd3;
	localparam logic [3:0] FRAME_LENGTH  = 4'd9;

	localparam int unsigned PAYLOAD_LEN = 6;

	localparam logic [1:0] EV_ENABLE  = 2'd0;
	localparam logic [1:0] EV_DISABLE = 2'd1;
	localparam logic [1:0] EV_VALUES  = 2'd2;

	localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

	// one received word
	typedef struct packed {
		logic [31:0] arrival_ms;
		logic [7:0]  data_byte;
	} item_t;

	// one result word
	typedef struct packed {
		logic [15:0] value_third;
		logic [15:0] value_second;
		logic [15:0] value_first;
		logic [1:0]  event_code;
	} result_t;

	// handshake between input stage and parser
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

/* src/sync_framed_command_parser.sv */
// sync_framed_command_parser: top level of the framed command parser.
// Depends on sfcp_pkg, sfcp_in_reg and sfcp_parser.
//
// Path: the word that completes a frame goes through the input register, then the result
// register. Throughput: one word per cycle while the result register is empty or draining,
// set by the state update in the parser. Reset (arst_n low) clears the hunt state, frame
// type, previous arrival time and result valid, and loads the gap timeout with 10000 ms;
// the payload store is not reset.
module sync_framed_command_parser import sfcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: gap timeout in ms
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// received words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] data_byte, [39:8] arrival_ms
	// parsed events
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // [1:0] event_code, [17:2] value_first,
	                              // [33:18] value_second, [49:34] value_third, rest zero
);

	item_t      in_item;
	item_t      item_s1;
	stage_ctl_t ctl;
	logic       advance;
	result_t    result_q;

	assign in_item.data_byte  = s_tdata[7:0];
	assign in_item.arrival_ms = s_tdata[39:8];

	// Stage 1: input register. Frees its slot whenever the parser takes the word,
	// so a new word enters every cycle while results keep draining.
	sfcp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	// Stage 2: gap check, sync hunt, type decode, payload capture and result register.
	// The parser consumes the stage-1 word when its result register is empty or
	// being drained this cycle.
	sfcp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_q  (result_q)
	);

	// result fields packed from the low bit up, padded to whole bytes
	assign m_tdata = {6'd0, result_q};

endmodule

/* src/sfcp_in_reg.sv */
// sfcp_in_reg: input register stage of the parser.
// Depends on sfcp_pkg for item_t and stage_ctl_t.
module sfcp_in_reg import sfcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_item,
	input  logic       advance,
	output stage_ctl_t ctl,
	output item_t      item_s1
);

	logic valid_s1;

	// slot frees when empty or when the parser consumes it this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign ctl.valid   = valid_s1;
	assign ctl.advance = advance;

endmodule

/* src/sfcp_parser.sv */
// sfcp_parser: frame state machine, payload store, gap timer and result register.
// Depends on sfcp_pkg for constants, item_t, result_t and stage_ctl_t.
module sfcp_parser import sfcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [31:0] cfg_wdata,
	input  stage_ctl_t ctl,
	input  item_t      item_s1,
	output logic       advance,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    result_q
);

	logic [3:0]  pos_q, pos_eff, pos_nx, pos_inc;
	logic [7:0]  type_q, type_nx;
	logic [7:0]  payload_q [PAYLOAD_LEN];
	logic [31:0] prev_q, timeout_q, gap;
	logic [2:0]  wr_idx;
	logic        wr_en, emit, timed_out;
	logic        out_valid_q;
	result_t     result_nx;

	assign out_valid = out_valid_q;
	assign advance   = ctl.valid && (!out_valid_q || out_ready);

	assign gap       = item_s1.arrival_ms - prev_q;
	assign timed_out = (gap > timeout_q) && (pos_q != POS_HUNT);
	assign pos_eff   = timed_out ? POS_HUNT : pos_q;
	assign pos_inc   = pos_eff + 4'd1;
	assign wr_idx    = 3'(pos_eff - PAYLOAD_START);

	always_comb begin
		pos_nx    = POS_HUNT;
		type_nx   = type_q;
		wr_en     = 1'b0;
		emit      = 1'b0;
		result_nx = '0;
		case (pos_eff)
			POS_HUNT: begin
				pos_nx = (item_s1.data_byte == SYNC_FIRST) ? POS_SYNC : POS_HUNT;
			end
			POS_SYNC: begin
				pos_nx = (item_s1.data_byte == SYNC_SECOND) ? POS_TYPE : POS_HUNT;
			end
			POS_TYPE: begin
				type_nx = item_s1.data_byte;
				if (item_s1.data_byte == TYPE_ENABLE) begin
					emit                 = 1'b1;
					result_nx.event_code = EV_ENABLE;
				end else if (item_s1.data_byte == TYPE_DISABLE) begin
					emit                 = 1'b1;
					result_nx.event_code = EV_DISABLE;
				end else if (item_s1.data_byte == TYPE_VALUES) begin
					pos_nx = PAYLOAD_START;
				end
			end
			default: begin
				if (pos_eff < FRAME_LENGTH) begin
					wr_en = 1'b1;
					if (pos_inc == FRAME_LENGTH) begin
						// last payload byte arrives now; bypass the store for it
						if (type_q == TYPE_VALUES) begin
							emit                   = 1'b1;
							result_nx.event_code   = EV_VALUES;
							result_nx.value_first  = {payload_q[1], payload_q[0]};
							result_nx.value_second = {payload_q[3], payload_q[2]};
							result_nx.value_third  = {item_s1.data_byte, payload_q[4]};
						end
					end else begin
						pos_nx = pos_inc;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HUNT;
			type_q      <= '0;
			prev_q      <= '0;
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (advance) begin
				pos_q  <= pos_nx;
				type_q <= type_nx;
				prev_q <= item_s1.arrival_ms;
			end
			if (advance) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result_nx;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			if (advance && wr_en && (wr_idx == 3'(i))) begin
				payload_q[i] <= item_s1.data_byte;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < FRAME_LENGTH)
		else $error("frame position out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("pending result would be overwritten");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.event_code != 2'd3)
		else $error("illegal event code");

	a_emit_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> pos_q == POS_HUNT)
		else $error("frame not closed after result");

	a_timeout_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && timed_out |-> !emit)
		else $error("result from a timed-out frame");

endmodule
